// File: hw/rtl/vr_pkg.sv
`default_nettype none
package vr_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 18;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [31:0]       len;
    logic [2:0][49:0]  rem;
    logic [2:0][17:0]  q;
  } div_t;

  typedef struct packed {
    logic [2:0]        neg;
    logic [2:0][23:0]  dmag;
    logic [2:0][17:0]  n;
    logic [19:0]       eta;
    logic              zero;
  } side_t;

  typedef struct packed {
    logic [2:0][17:0]  n;
    logic [19:0]       eta;
    logic              zero;
  } tail_t;

  // drop 16 fraction bits, round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + 64'd32768) >> 16;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [23:0] sat24(input logic signed [35:0] v);
    logic [23:0] r;
    if (v > 36'sd8388607) begin
      r = 24'h7FFFFF;
    end else if (v < -36'sd8388608) begin
      r = 24'h800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/vr_sqrt_cell.sv
`default_nettype none
module vr_sqrt_cell (
  input  wire logic          clk,
  input  wire logic [63:0]   bit_val,
  input  wire vr_pkg::sqrt_t in_d,
  output vr_pkg::sqrt_t      out_q
);

  vr_pkg::sqrt_t stage_r;
  vr_pkg::sqrt_t stage_nxt;
  logic [63:0]   trial;

  always_comb begin
    trial = in_d.res + bit_val;
    if (in_d.v >= trial) begin
      stage_nxt.v   = in_d.v - trial;
      stage_nxt.res = (in_d.res >> 1) + bit_val;
    end else begin
      stage_nxt.v   = in_d.v;
      stage_nxt.res = in_d.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign out_q = stage_r;

endmodule
`default_nettype wire

// File: hw/rtl/vr_div_cell.sv
`default_nettype none
module vr_div_cell (
  input  wire logic         clk,
  input  wire logic [4:0]   shamt,
  input  wire vr_pkg::div_t in_d,
  output vr_pkg::div_t      out_q
);

  vr_pkg::div_t stage_r;
  vr_pkg::div_t stage_nxt;
  logic [49:0]  divisor;

  always_comb begin
    divisor = {18'd0, in_d.len} << shamt;
    stage_nxt.len = in_d.len;
    for (int i = 0; i < 3; i++) begin
      if (in_d.rem[i] >= divisor) begin
        stage_nxt.rem[i] = in_d.rem[i] - divisor;
        stage_nxt.q[i]   = in_d.q[i] | (18'd1 << shamt);
      end else begin
        stage_nxt.rem[i] = in_d.rem[i];
        stage_nxt.q[i]   = in_d.q[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  assign out_q = stage_r;

endmodule
`default_nettype wire

// File: hw/rtl/vector_refraction.sv
// Fully pipelined vector refraction: one ray is taken in every clock cycle
// (busy is always low) and its result appears on the out_ ports for one cycle,
// marked by out_valid. The pipeline holds two chains of 32 square-root cells
// (length and parallel term) and a chain of 18 divider cells (normalization).
// The receiver cannot stall the block; results must be taken in the cycle
// they are shown.
`default_nettype none
module vector_refraction (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [23:0] in_incident_x,
  input  wire logic [23:0] in_incident_y,
  input  wire logic [23:0] in_incident_z,
  input  wire logic [17:0] in_normal_x,
  input  wire logic [17:0] in_normal_y,
  input  wire logic [17:0] in_normal_z,
  input  wire logic [19:0] in_eta_ratio,
  output logic             out_valid,
  output logic [23:0]      out_refracted_x,
  output logic [23:0]      out_refracted_y,
  output logic [23:0]      out_refracted_z,
  output logic             out_zero_direction
);

  localparam int NSQ  = vr_pkg::SQRT_STEPS;
  localparam int NDIV = vr_pkg::DIV_STEPS;

  logic                  accept;
  logic [2:0][23:0]      din;
  vr_pkg::side_t         side_in;

  // stage a: squares
  logic                  vld_a_r;
  vr_pkg::side_t         side_a_r;
  logic [2:0][47:0]      sq_a_r;

  // stage b: sum
  logic                  vld_b_r;
  vr_pkg::side_t         side_b_r;
  vr_pkg::sqrt_t         sqin_b_r;
  logic [47:0]           sumsq;

  // length chain
  vr_pkg::sqrt_t         sq1 [NSQ+1];
  logic                  vld1_r [1:NSQ];
  vr_pkg::side_t         side1_r [1:NSQ];

  // divider chain
  vr_pkg::div_t          dv [NDIV+1];
  logic                  vld2_r [1:NDIV];
  vr_pkg::side_t         side2_r [1:NDIV];

  logic                  vld_c_r, vld_d_r, vld_e_r, vld_f_r, vld_g_r, vld_h_r;
  vr_pkg::tail_t         tail_c_r, tail_d_r, tail_e_r, tail_f_r, tail_g_r, tail_h_r;
  logic signed [18:0]    u_c_r [3];
  logic signed [36:0]    prod_c_r [3];
  logic signed [18:0]    u_d_r [3];
  logic signed [21:0]    cos_d_r;
  logic signed [18:0]    u_e_r [3];
  logic signed [39:0]    cn_e_r [3];
  logic signed [43:0]    et_f_r [3];
  logic signed [26:0]    perp_g_r [3];
  logic [51:0]           psq_g_r [3];
  logic signed [26:0]    perp_h_r [3];
  vr_pkg::sqrt_t         sqin_h_r;

  // parallel term chain
  vr_pkg::sqrt_t         sq2 [NSQ+1];
  logic                  vld3_r [1:NSQ];
  vr_pkg::tail_t         tail3_r [1:NSQ];
  logic signed [26:0]    perp3_r [1:NSQ][3];

  logic                  vld_i_r;
  logic                  zero_i_r;
  logic signed [26:0]    perp_i_r [3];
  logic signed [50:0]    sn_i_r [3];

  logic                  out_valid_r;
  logic                  out_zero_r;
  logic [2:0][23:0]      out_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign din    = {in_incident_z, in_incident_y, in_incident_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      side_in.neg[i]  = din[i][23];
      side_in.dmag[i] = din[i][23] ? (~din[i] + 24'd1) : din[i];
    end
    side_in.n    = {in_normal_z, in_normal_y, in_normal_x};
    side_in.eta  = in_eta_ratio;
    side_in.zero = 1'b0;
  end

  always_ff @(posedge clk) begin
    side_a_r <= side_in;
    for (int i = 0; i < 3; i++) begin
      sq_a_r[i] <= side_in.dmag[i] * side_in.dmag[i];
    end
  end

  assign sumsq = sq_a_r[0] + sq_a_r[1] + sq_a_r[2];

  always_ff @(posedge clk) begin
    side_b_r.neg  <= side_a_r.neg;
    side_b_r.dmag <= side_a_r.dmag;
    side_b_r.n    <= side_a_r.n;
    side_b_r.eta  <= side_a_r.eta;
    side_b_r.zero <= (sumsq == 48'd0);
    sqin_b_r.v    <= {sumsq, 16'd0};
    sqin_b_r.res  <= 64'd0;
  end

  assign sq1[0] = sqin_b_r;

  for (genvar k = 0; k < NSQ; k++) begin : g_len
    vr_sqrt_cell u_cell (
      .clk     (clk),
      .bit_val (64'd1 << (62 - 2 * k)),
      .in_d    (sq1[k]),
      .out_q   (sq1[k+1])
    );
  end

  always_ff @(posedge clk) begin
    side1_r[1] <= side_b_r;
    for (int k = 2; k <= NSQ; k++) begin
      side1_r[k] <= side1_r[k-1];
    end
  end

  always_comb begin
    dv[0].len = sq1[NSQ].res[31:0];
    for (int i = 0; i < 3; i++) begin
      dv[0].rem[i] = {2'd0, side1_r[NSQ].dmag[i], 24'd0};
      dv[0].q[i]   = 18'd0;
    end
  end

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    vr_div_cell u_cell (
      .clk   (clk),
      .shamt (5'(NDIV - 1 - j)),
      .in_d  (dv[j]),
      .out_q (dv[j+1])
    );
  end

  always_ff @(posedge clk) begin
    side2_r[1] <= side1_r[NSQ];
    for (int k = 2; k <= NDIV; k++) begin
      side2_r[k] <= side2_r[k-1];
    end
  end

  // stage c: unit direction and products with the normal
  always_ff @(posedge clk) begin
    tail_c_r.n    <= side2_r[NDIV].n;
    tail_c_r.eta  <= side2_r[NDIV].eta;
    tail_c_r.zero <= side2_r[NDIV].zero;
    for (int i = 0; i < 3; i++) begin
      u_c_r[i]    <= side2_r[NDIV].neg[i] ? -$signed({1'b0, dv[NDIV].q[i]})
                                          : $signed({1'b0, dv[NDIV].q[i]});
      prod_c_r[i] <= (side2_r[NDIV].neg[i] ? -$signed({1'b0, dv[NDIV].q[i]})
                                           : $signed({1'b0, dv[NDIV].q[i]}))
                     * $signed(side2_r[NDIV].n[i]);
    end
  end

  // stage d: cosine
  always_ff @(posedge clk) begin
    logic signed [63:0] dot;
    dot = 64'(prod_c_r[0]) + 64'(prod_c_r[1]) + 64'(prod_c_r[2]);
    cos_d_r  <= 22'(vr_pkg::rnd16(-dot));
    tail_d_r <= tail_c_r;
    u_d_r    <= u_c_r;
  end

  // stage e: cosine times normal
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      cn_e_r[i] <= cos_d_r * $signed(tail_d_r.n[i]);
    end
    tail_e_r <= tail_d_r;
    u_e_r    <= u_d_r;
  end

  // stage f: eta times (u + cos n)
  always_ff @(posedge clk) begin
    logic signed [22:0] t;
    for (int i = 0; i < 3; i++) begin
      t = 23'(u_e_r[i]) + 23'(vr_pkg::rnd16(64'(cn_e_r[i])));
      et_f_r[i] <= $signed({1'b0, tail_e_r.eta}) * t;
    end
    tail_f_r <= tail_e_r;
  end

  // stage g: perpendicular part and its squares
  always_ff @(posedge clk) begin
    logic signed [26:0] p;
    logic [25:0]        pm;
    for (int i = 0; i < 3; i++) begin
      p  = 27'(vr_pkg::rnd16(64'(et_f_r[i])));
      pm = p[26] ? 26'(-p) : p[25:0];
      perp_g_r[i] <= p;
      psq_g_r[i]  <= pm * pm;
    end
    tail_g_r <= tail_f_r;
  end

  // stage h: |1 - |perp|^2|
  always_ff @(posedge clk) begin
    logic [53:0] psq;
    logic [53:0] one;
    one = 54'd1 << 32;
    psq = 54'(psq_g_r[0]) + 54'(psq_g_r[1]) + 54'(psq_g_r[2]);
    sqin_h_r.v   <= 64'((psq > one) ? (psq - one) : (one - psq));
    sqin_h_r.res <= 64'd0;
    perp_h_r     <= perp_g_r;
    tail_h_r     <= tail_g_r;
  end

  assign sq2[0] = sqin_h_r;

  for (genvar k = 0; k < NSQ; k++) begin : g_par
    vr_sqrt_cell u_cell (
      .clk     (clk),
      .bit_val (64'd1 << (62 - 2 * k)),
      .in_d    (sq2[k]),
      .out_q   (sq2[k+1])
    );
  end

  always_ff @(posedge clk) begin
    tail3_r[1] <= tail_h_r;
    perp3_r[1] <= perp_h_r;
    for (int k = 2; k <= NSQ; k++) begin
      tail3_r[k] <= tail3_r[k-1];
      perp3_r[k] <= perp3_r[k-1];
    end
  end

  // stage i: s times normal
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sn_i_r[i] <= $signed({1'b0, sq2[NSQ].res[31:0]}) * $signed(tail3_r[NSQ].n[i]);
    end
    perp_i_r <= perp3_r[NSQ];
    zero_i_r <= tail3_r[NSQ].zero;
  end

  // stage j: sum and saturate
  always_ff @(posedge clk) begin
    logic signed [35:0] r;
    for (int i = 0; i < 3; i++) begin
      r = 36'(perp_i_r[i]) + 36'(vr_pkg::rnd16(-64'(sn_i_r[i])));
      out_r[i] <= zero_i_r ? 24'd0 : vr_pkg::sat24(r);
    end
    out_zero_r <= zero_i_r;
  end

  // control pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r     <= 1'b0;
      vld_b_r     <= 1'b0;
      vld_c_r     <= 1'b0;
      vld_d_r     <= 1'b0;
      vld_e_r     <= 1'b0;
      vld_f_r     <= 1'b0;
      vld_g_r     <= 1'b0;
      vld_h_r     <= 1'b0;
      vld_i_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 1; k <= NSQ; k++) begin
        vld1_r[k] <= 1'b0;
        vld3_r[k] <= 1'b0;
      end
      for (int k = 1; k <= NDIV; k++) begin
        vld2_r[k] <= 1'b0;
      end
    end else begin
      vld_a_r   <= accept;
      vld_b_r   <= vld_a_r;
      vld1_r[1] <= vld_b_r;
      for (int k = 2; k <= NSQ; k++) begin
        vld1_r[k] <= vld1_r[k-1];
        vld3_r[k] <= vld3_r[k-1];
      end
      vld2_r[1] <= vld1_r[NSQ];
      for (int k = 2; k <= NDIV; k++) begin
        vld2_r[k] <= vld2_r[k-1];
      end
      vld_c_r     <= vld2_r[NDIV];
      vld_d_r     <= vld_c_r;
      vld_e_r     <= vld_d_r;
      vld_f_r     <= vld_e_r;
      vld_g_r     <= vld_f_r;
      vld_h_r     <= vld_g_r;
      vld3_r[1]   <= vld_h_r;
      vld_i_r     <= vld3_r[NSQ];
      out_valid_r <= vld_i_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_refracted_x    = out_r[0];
  assign out_refracted_y    = out_r[1];
  assign out_refracted_z    = out_r[2];
  assign out_zero_direction = out_zero_r;

endmodule
`default_nettype wire
